>>> sv/tss_pkg.sv
// shared types, constants and fixed-point helpers of the tridiagonal solver
package tss_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAX_ROWS  = 64;
  localparam int ROW_AW    = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);
  localparam int DIV_W     = DATA_W + FRAC_BITS;
  localparam int DCNT_W    = $clog2(DIV_W + 1);

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_PIVOT = 2'd1;
  localparam logic [1:0] ST_TOO_MANY   = 2'd2;

  localparam logic [1:0] MUL_LC = 2'd0;
  localparam logic [1:0] MUL_LY = 2'd1;
  localparam logic [1:0] MUL_CX = 2'd2;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic       load_row;
    logic       drop_row;
    logic       first_row;
    logic       div_start;
    logic       div_back;
    logic       take_l;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       calc_u;
    logic       calc_y;
    logic       back_init;
    logic       calc_num;
    logic       x_write;
    logic       out_load;
    logic       out_next;
    logic       clear_sys;
  } cmd_t;

  typedef struct packed {
    logic row_full;
    logic row_empty;
    logic last_flag;
    logic div_done;
    logic k_top;
    logic k_zero;
    logic j_last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero_den;
  } div_sts_t;

  // floor shift of a full product, saturated
  function automatic logic signed [DATA_W-1:0] mul_sat(input logic signed [2*DATA_W-1:0] p);
    logic signed [2*DATA_W-1:0] s;
    s = p >>> FRAC_BITS;
    if ((&s[2*DATA_W-1:DATA_W-1]) || !(|s[2*DATA_W-1:DATA_W-1]))
      return s[DATA_W-1:0];
    else
      return s[2*DATA_W-1] ? S_MIN : S_MAX;
  endfunction

  function automatic logic signed [DATA_W-1:0] sub_sat(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (d[DATA_W] == d[DATA_W-1])
      return d[DATA_W-1:0];
    else
      return d[DATA_W] ? S_MIN : S_MAX;
  endfunction

endpackage

>>> sv/tss_row_if.sv
// row input channel
interface tss_row_if import tss_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sub_diagonal;
  logic signed [DATA_W-1:0] diagonal;
  logic signed [DATA_W-1:0] super_diagonal;
  logic signed [DATA_W-1:0] right_side;
  logic                     last_row;

  modport source (output valid, sub_diagonal, diagonal, super_diagonal, right_side, last_row,
                  input ready);
  modport sink (input valid, sub_diagonal, diagonal, super_diagonal, right_side, last_row,
                output ready);
endinterface

>>> sv/tss_sol_if.sv
// solution output channel
interface tss_sol_if import tss_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] solution;
  logic [1:0]               status;
  logic                     last_result;

  modport source (output valid, solution, status, last_result, input ready);
  modport sink (input valid, solution, status, last_result, output ready);
endinterface

>>> sv/tridiagonal_system_solver.sv
// top level of the tridiagonal system solver
//
//   channel  dir  payload                                                 transfer
//   rows     in   sub_diagonal diagonal super_diagonal right_side last_row  valid & ready
//   sols     out  solution status last_result                             valid & ready
//
// a row other than the first goes through one 48-step divider pass plus
// two multiply/subtract steps; the first row and a dropped row skip both
// back substitution makes one divider pass per row, then each solution
// entry leaves through the output register
// rows are refused from the last row until the final solution entry is loaded
// rst is synchronous and clears the row count, status and all handshake state
module tridiagonal_system_solver import tss_pkg::*; (
  input logic     clk,
  input logic     rst,
  tss_row_if.sink rows,
  tss_sol_if.source sols
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign rows.ready = in_ready;

  tss_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rows.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tss_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .sub_diagonal   (rows.sub_diagonal),
    .diagonal       (rows.diagonal),
    .super_diagonal (rows.super_diagonal),
    .right_side     (rows.right_side),
    .last_row       (rows.last_row),
    .sol_valid      (sols.valid),
    .sol_ready      (sols.ready),
    .solution       (sols.solution),
    .status         (sols.status),
    .last_result    (sols.last_result)
  );

endmodule

>>> sv/tss_divider.sv
// radix-2 restoring divider for saturated fixed-point quotients
module tss_divider import tss_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] num,
  input  logic signed [DATA_W-1:0] den,
  output div_sts_t                 sts,
  output logic signed [DATA_W-1:0] quotient
);

  localparam logic [DIV_W-1:0] POS_LIM = {{(DIV_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DIV_W-1:0] NEG_LIM = {{(DIV_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};

  logic              busy;
  logic              done;
  logic              zero_den;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dmag;
  logic              neg;

  logic [DATA_W-1:0] num_mag;
  logic [DATA_W-1:0] den_mag;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;

  assign num_mag = num[DATA_W-1] ? (~num + DATA_W'(1)) : num;
  assign den_mag = den[DATA_W-1] ? (~den + DATA_W'(1)) : den;
  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign diff    = rem_sh - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      zero_den <= 1'b0;
      cnt      <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        zero_den <= (den == '0);
        neg      <= num[DATA_W-1] ^ den[DATA_W-1];
        rem      <= '0;
        dmag     <= den_mag;
        quo      <= (den == '0) ? '0 : {num_mag, {FRAC_BITS{1'b0}}};
        cnt      <= DCNT_W'(DIV_W);
        busy     <= (den != '0);
        done     <= (den == '0);
      end else if (busy) begin
        if (!diff[DATA_W]) begin
          rem <= diff[DATA_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DATA_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg)
      quotient = (quo > NEG_LIM) ? S_MIN : (~quo[DATA_W-1:0] + DATA_W'(1));
    else
      quotient = (quo > POS_LIM) ? S_MAX : quo[DATA_W-1:0];
  end

  assign sts.busy     = busy;
  assign sts.done     = done;
  assign sts.zero_den = zero_den;

endmodule

>>> sv/tss_datapath.sv
// factor/substitution datapath: row stores, multiplier, divider, output register
module tss_datapath import tss_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic signed [DATA_W-1:0] sub_diagonal,
  input  logic signed [DATA_W-1:0] diagonal,
  input  logic signed [DATA_W-1:0] super_diagonal,
  input  logic signed [DATA_W-1:0] right_side,
  input  logic                     last_row,
  output logic                     sol_valid,
  input  logic                     sol_ready,
  output logic signed [DATA_W-1:0] solution,
  output logic [1:0]               status,
  output logic                     last_result
);

  logic signed [DATA_W-1:0] pivot_mem [MAX_ROWS];
  logic signed [DATA_W-1:0] band_mem  [MAX_ROWS];
  logic signed [DATA_W-1:0] fwd_mem   [MAX_ROWS];
  logic signed [DATA_W-1:0] x_mem     [MAX_ROWS];

  logic signed [DATA_W-1:0]   sub_hold, diag_hold, sup_hold, rhs_hold;
  logic                       last_hold;
  logic signed [DATA_W-1:0]   l_factor, u_new;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [DATA_W-1:0]   prev_pivot, prev_band, prev_fwd;
  logic signed [DATA_W-1:0]   back_num, x_above;
  logic signed [DATA_W-1:0]   rd_pivot, rd_band, rd_fwd, rd_x;
  logic [CNT_W-1:0]           row_count;
  logic [1:0]                 err_code;
  logic [ROW_AW-1:0]          k_idx, j_idx;

  logic [CNT_W-1:0]         top_full;
  logic [ROW_AW-1:0]        top_idx;
  logic [ROW_AW-1:0]        wr_idx;
  logic                     mem_we;
  logic signed [DATA_W-1:0] wr_pivot, wr_fwd, y_new;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [DATA_W-1:0] div_num, div_den, quotient;
  div_sts_t                 div_sts;

  assign top_full = row_count - CNT_W'(1);
  assign top_idx  = top_full[ROW_AW-1:0];
  assign wr_idx   = row_count[ROW_AW-1:0];
  assign y_new    = sub_sat(rhs_hold, mul_sat(prod));
  assign mem_we   = cmd.first_row || cmd.calc_y;
  assign wr_pivot = cmd.first_row ? diag_hold : u_new;
  assign wr_fwd   = cmd.first_row ? rhs_hold : y_new;
  assign div_num  = cmd.div_back ? back_num : sub_hold;
  assign div_den  = cmd.div_back ? rd_pivot : prev_pivot;

  always_comb begin
    case (cmd.mul_sel)
      MUL_LC: begin mul_a = l_factor; mul_b = prev_band; end
      MUL_LY: begin mul_a = l_factor; mul_b = prev_fwd; end
      MUL_CX: begin mul_a = rd_band;  mul_b = x_above; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  tss_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (div_num),
    .den      (div_den),
    .sts      (div_sts),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pivot_mem[wr_idx] <= wr_pivot;
      band_mem[wr_idx]  <= sup_hold;
      fwd_mem[wr_idx]   <= wr_fwd;
    end
    if (cmd.x_write)
      x_mem[k_idx] <= quotient;
    rd_pivot <= pivot_mem[k_idx];
    rd_band  <= band_mem[k_idx];
    rd_fwd   <= fwd_mem[k_idx];
    rd_x     <= x_mem[j_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      sub_hold  <= sub_diagonal;
      diag_hold <= diagonal;
      sup_hold  <= super_diagonal;
      rhs_hold  <= right_side;
      last_hold <= last_row;
    end
    if (cmd.take_l)
      l_factor <= quotient;
    if (cmd.mul_en)
      prod <= mul_a * mul_b;
    if (cmd.calc_u)
      u_new <= sub_sat(diag_hold, mul_sat(prod));
    if (mem_we) begin
      prev_pivot <= wr_pivot;
      prev_band  <= sup_hold;
      prev_fwd   <= wr_fwd;
    end
    if (cmd.calc_num)
      back_num <= sts.k_top ? rd_fwd : sub_sat(rd_fwd, mul_sat(prod));
    if (cmd.x_write)
      x_above <= quotient;
    if (cmd.out_load) begin
      solution    <= rd_x;
      status      <= err_code;
      last_result <= (j_idx == top_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      err_code  <= ST_OK;
      k_idx     <= '0;
      j_idx     <= '0;
      sol_valid <= 1'b0;
    end else begin
      if (mem_we)
        row_count <= row_count + CNT_W'(1);
      if (cmd.drop_row && err_code == ST_OK)
        err_code <= ST_TOO_MANY;
      if (div_sts.done && div_sts.zero_den && err_code == ST_OK)
        err_code <= ST_ZERO_PIVOT;
      if (cmd.back_init) begin
        k_idx <= top_idx;
        j_idx <= '0;
      end
      if (cmd.x_write && k_idx != '0)
        k_idx <= k_idx - ROW_AW'(1);
      if (cmd.out_next)
        j_idx <= j_idx + ROW_AW'(1);
      if (cmd.clear_sys) begin
        row_count <= '0;
        err_code  <= ST_OK;
      end
      if (cmd.out_load)
        sol_valid <= 1'b1;
      else if (sol_ready)
        sol_valid <= 1'b0;
    end
  end

  assign sts.row_full  = (row_count == CNT_W'(MAX_ROWS));
  assign sts.row_empty = (row_count == '0);
  assign sts.last_flag = last_hold;
  assign sts.div_done  = div_sts.done;
  assign sts.k_top     = (k_idx == top_idx);
  assign sts.k_zero    = (k_idx == '0);
  assign sts.j_last    = (j_idx == top_idx);
  assign sts.out_free  = !sol_valid || sol_ready;

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= CNT_W'(MAX_ROWS)) else $error("row count beyond capacity");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!sol_valid || sol_ready)) else $error("output overwritten");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_sts.busy) else $error("divider restarted while busy");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_sys |=> (row_count == '0 && err_code == ST_OK)) else $error("system not cleared");

endmodule

>>> sv/tss_controller.sv
// sequencer for row factoring, back substitution and result streaming
module tss_controller import tss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_FWAIT = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_SUB1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_SUB2  = 4'd6;
  localparam logic [3:0] S_BINIT = 4'd7;
  localparam logic [3:0] S_BRD   = 4'd8;
  localparam logic [3:0] S_BUSE  = 4'd9;
  localparam logic [3:0] S_BSUB  = 4'd10;
  localparam logic [3:0] S_BDIV  = 4'd11;
  localparam logic [3:0] S_BWAIT = 4'd12;
  localparam logic [3:0] S_ORD   = 4'd13;
  localparam logic [3:0] S_OLOAD = 4'd14;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_row = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.row_full) begin
          cmd.drop_row = 1'b1;
          state_next   = sts.last_flag ? S_BINIT : S_IDLE;
        end else if (sts.row_empty) begin
          cmd.first_row = 1'b1;
          state_next    = sts.last_flag ? S_BINIT : S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (sts.div_done) begin
          cmd.take_l = 1'b1;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LC;
        state_next  = S_SUB1;
      end
      S_SUB1: begin
        cmd.calc_u = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LY;
        state_next  = S_SUB2;
      end
      S_SUB2: begin
        cmd.calc_y = 1'b1;
        state_next = sts.last_flag ? S_BINIT : S_IDLE;
      end
      S_BINIT: begin
        if (sts.row_empty) begin
          cmd.clear_sys = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.back_init = 1'b1;
          state_next    = S_BRD;
        end
      end
      S_BRD: state_next = S_BUSE;
      S_BUSE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CX;
        state_next  = S_BSUB;
      end
      S_BSUB: begin
        cmd.calc_num = 1'b1;
        state_next   = S_BDIV;
      end
      S_BDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_back  = 1'b1;
        state_next    = S_BWAIT;
      end
      S_BWAIT: begin
        if (sts.div_done) begin
          cmd.x_write = 1'b1;
          state_next  = sts.k_zero ? S_ORD : S_BRD;
        end
      end
      S_ORD: state_next = S_OLOAD;
      S_OLOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.j_last) begin
            cmd.clear_sys = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.out_next = 1'b1;
            state_next   = S_ORD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> tb/tridiagonal_system_solver_test.sv
// self-checking testbench of the tridiagonal system solver
`timescale 1ns / 1ps

module tridiagonal_system_solver_test;
  import tss_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] r;
    logic                     last;
    logic                     typed;
    logic signed [DATA_W-1:0] x_exp;
    logic [1:0]               st_exp;
  } row_t;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic [1:0]               st;
    logic                     last;
  } sol_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit failed = 1'b0;
  bit stim_done = 1'b0;
  int idle_cycles = 0;
  int src_idle_pct = 38;
  int snk_idle_pct = 46;

  tss_row_if rows ();
  tss_sol_if sols ();

  tridiagonal_system_solver uut (.clk(clk), .rst(rst), .rows(rows), .sols(sols));

  always #1 clk = ~clk;

  // solver state mirror
  logic signed [DATA_W-1:0] m_u [MAX_ROWS];
  logic signed [DATA_W-1:0] m_c [MAX_ROWS];
  logic signed [DATA_W-1:0] m_y [MAX_ROWS];
  int m_count = 0;
  logic [1:0] m_err = ST_OK;
  sol_t expected_sols[$];
  bit typed_q[$];
  row_t typed_rows[$];

  function automatic logic signed [DATA_W-1:0] clamp(input longint v);
    if (v > 64'sd2147483647) return S_MAX;
    if (v < -64'sd2147483648) return S_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] fmul(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [DATA_W-1:0] fsub(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    return clamp(longint'(a) - longint'(b));
  endfunction

  function automatic logic signed [DATA_W-1:0] fdiv(input logic signed [DATA_W-1:0] n,
                                                    input logic signed [DATA_W-1:0] d);
    if (d == 0) begin
      if (m_err == ST_OK) m_err = ST_ZERO_PIVOT;
      return '0;
    end
    return clamp((longint'(n) * (64'sd1 <<< FRAC_BITS)) / longint'(d));
  endfunction

  task automatic solve_row(input row_t rw);
    logic signed [DATA_W-1:0] l;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] xs [MAX_ROWS];
    sol_t s;
    if (m_count >= MAX_ROWS) begin
      if (m_err == ST_OK) m_err = ST_TOO_MANY;
    end else begin
      if (m_count == 0) begin
        m_u[0] = rw.b;
        m_y[0] = rw.r;
      end else begin
        l = fdiv(rw.a, m_u[m_count-1]);
        m_u[m_count] = fsub(rw.b, fmul(l, m_c[m_count-1]));
        m_y[m_count] = fsub(rw.r, fmul(l, m_y[m_count-1]));
      end
      m_c[m_count] = rw.c;
      m_count++;
    end
    if (!rw.last) return;
    for (int k = m_count - 1; k >= 0; k--) begin
      num = m_y[k];
      if (k + 1 < m_count) num = fsub(num, fmul(m_c[k], xs[k+1]));
      xs[k] = fdiv(num, m_u[k]);
    end
    for (int i = 0; i < m_count; i++) begin
      s.x = xs[i];
      s.st = m_err;
      s.last = (i + 1 == m_count);
      expected_sols.push_back(s);
      typed_q.push_back(rw.typed && m_count == 1);
      if (rw.typed && m_count == 1) typed_rows.push_back(rw);
    end
    m_count = 0;
    m_err = ST_OK;
  endtask

  function automatic logic signed [DATA_W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return S_MAX;
      2: return S_MIN;
      3: return '0;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic send_row(input row_t rw);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rows.valid <= 1'b0;
      @(negedge clk);
    end
    rows.valid <= 1'b1;
    rows.sub_diagonal <= rw.a;
    rows.diagonal <= rw.b;
    rows.super_diagonal <= rw.c;
    rows.right_side <= rw.r;
    rows.last_row <= rw.last;
    @(posedge clk);
    while (!rows.ready) @(posedge clk);
    solve_row(rw);
  endtask

  function automatic row_t mk(input logic signed [DATA_W-1:0] a, b, c, r,
                              input logic last);
    row_t rw;
    rw.a = a; rw.b = b; rw.c = c; rw.r = r; rw.last = last;
    rw.typed = 1'b0; rw.x_exp = '0; rw.st_exp = ST_OK;
    return rw;
  endfunction

  function automatic row_t mkt(input logic signed [DATA_W-1:0] b, r,
                               input logic signed [DATA_W-1:0] x,
                               input logic [1:0] st);
    row_t rw;
    rw = mk(S_MAX, b, S_MIN, r, 1'b1);
    rw.typed = 1'b1; rw.x_exp = x; rw.st_exp = st;
    return rw;
  endfunction

  row_t directed[$];

  initial begin
    rows.valid = 1'b0;
    rows.sub_diagonal = '0;
    rows.diagonal = '0;
    rows.super_diagonal = '0;
    rows.right_side = '0;
    rows.last_row = 1'b0;
    sols.ready = 1'b0;
    // single-row systems read off at a glance
    directed.push_back(mkt(32'sh0001_0000, 32'sh0003_0000, 32'sh0003_0000, ST_OK));
    directed.push_back(mkt(32'sh0000_0000, 32'sh0003_0000, 32'sh0000_0000, ST_ZERO_PIVOT));
    directed.push_back(mkt(32'sh0000_0001, S_MAX, S_MAX, ST_OK));
    directed.push_back(mkt(32'sh0000_0001, S_MIN, S_MIN, ST_OK));
    directed.push_back(mkt(-32'sh0001_0000, 32'sh0002_0000, -32'sh0002_0000, ST_OK));
    // two and three row systems
    directed.push_back(mk(32'sh1234_5678, 32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000,
                          1'b0));
    directed.push_back(mk(32'sh0001_0000, 32'sh0002_0000, S_MAX, 32'sh0001_0000, 1'b1));
    directed.push_back(mk(S_MIN, S_MAX, S_MIN, S_MAX, 1'b0));
    directed.push_back(mk(S_MAX, S_MIN, S_MAX, S_MIN, 1'b0));
    directed.push_back(mk(32'sh0000_0000, 32'sh0000_0000, S_MAX, S_MIN, 1'b1));
    // zero pivot in the middle
    directed.push_back(mk(0, 0, 32'sh0001_0000, 32'sh0001_0000, 1'b0));
    directed.push_back(mk(32'sh0001_0000, 32'sh0001_0000, 0, 32'sh0002_0000, 1'b1));
    directed.push_back(mk(-1, -1, -1, -1, 1'b0));
    directed.push_back(mk(-1, -1, -1, -1, 1'b1));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_row(directed[i]);
    // overflow past the row store, last row dropped
    for (int i = 0; i < MAX_ROWS + 2; i++)
      send_row(mk(rand_val(), 32'sh0004_0000 + $urandom_range(0, 255), rand_val(),
                  rand_val(), i == MAX_ROWS + 1));
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 46 : 0;
      snk_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 38 : 0;
      for (int n = 0; n < 70; ) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
        for (int j = 0; j < len; j++) begin
          row_t rw;
          rw = mk(rand_val(), rand_val(), rand_val(), rand_val(), j == len - 1);
          if ($urandom_range(0, 3) != 0) begin
            rw.b = 32'sh0004_0000 + $signed($urandom_range(0, 32'h0003_ffff));
            if ($urandom_range(0, 1)) rw.b = -rw.b;
            rw.a = $signed($urandom_range(0, 32'h0001_ffff)) - 32'sh0001_0000;
            rw.c = $signed($urandom_range(0, 32'h0001_ffff)) - 32'sh0001_0000;
          end
          send_row(rw);
        end
        n += len;
      end
    end
    @(negedge clk);
    rows.valid <= 1'b0;
    stim_done = 1'b1;
  end

  always @(negedge clk) begin
    sols.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    sol_t e;
    row_t t;
    if (!rst) begin
      if ((rows.valid && rows.ready) || (sols.valid && sols.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (sols.valid && sols.ready) begin
        if (expected_sols.size() == 0) begin
          $error("unexpected solution transfer: solution %0d", sols.solution);
          failed = 1'b1;
        end else begin
          e = expected_sols.pop_front();
          if (typed_q.pop_front()) begin
            t = typed_rows.pop_front();
            e.x = t.x_exp;
            e.st = t.st_exp;
          end
          if (sols.solution !== e.x) begin
            $error("solution: expected %0d actual %0d", e.x, sols.solution);
            failed = 1'b1;
          end
          if (sols.status !== e.st) begin
            $error("status: expected %0d actual %0d", e.st, sols.status);
            failed = 1'b1;
          end
          if (sols.last_result !== e.last) begin
            $error("last_result: expected %0d actual %0d", e.last, sols.last_result);
            failed = 1'b1;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tridiagonal_system_solver_test failed");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_sols.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!failed && expected_sols.size() == 0) begin
      $display("tridiagonal_system_solver_test passed");
    end else begin
      $display("tridiagonal_system_solver_test failed");
    end
    $finish;
  end

endmodule
